/* design/timeline_cue_crossing_scheduler_core_defines.svh */
// Assertion macros used by the cue crossing scheduler sequencer (tccs_ctrl).
`ifndef TIMELINE_CUE_CROSSING_SCHEDULER_CORE_DEFINES_SVH
`define TIMELINE_CUE_CROSSING_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define TCCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define TCCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/tccs_pkg.sv */
// Types, constants and the cue table of the cue crossing scheduler.
package tccs_pkg;

    localparam int NOW_W       = 25;
    localparam int TOL_W       = 10;
    localparam int IDX_W       = 4;
    localparam int CUE_TIME_W  = 24;
    localparam int DIR_W       = 2;
    localparam int INTENS_W    = 8;
    localparam int TABLE_LEN   = 14;
    localparam int CMP_W       = 33;

    localparam logic [TOL_W-1:0] TOL_RESET = 10'd10;

    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam logic signed [DIR_W-1:0] DIR_FWD = 2'sb01;
    localparam logic signed [DIR_W-1:0] DIR_REV = 2'sb11;

    localparam logic [INTENS_W-1:0] INTENS_STD = 8'd32;

    typedef struct packed {
        logic [CUE_TIME_W-1:0]         time_ms;
        logic signed [DIR_W-1:0]       dir;
        logic [INTENS_W-1:0]           intensity;
    } cue_t;

    typedef struct packed {
        logic hit;
        cue_t cue;
    } walk_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEEK,
        ST_SCAN
    } ctrl_state_t;

    function automatic cue_t cue_lookup(input logic [IDX_W-1:0] idx);
        cue_t c;
        c.intensity = INTENS_STD;
        c.dir       = DIR_FWD;
        c.time_ms   = '0;
        unique case (idx)
            4'd0:  c.time_ms = 24'd14000;
            4'd1:  c.time_ms = 24'd25000;
            4'd2:  c.time_ms = 24'd36000;
            4'd3:  c.time_ms = 24'd47000;
            4'd4:  c.time_ms = 24'd59000;
            4'd5:  begin c.time_ms = 24'd71000;  c.dir = DIR_REV; end
            4'd6:  c.time_ms = 24'd82000;
            4'd7:  begin c.time_ms = 24'd93000;  c.dir = DIR_REV; end
            4'd8:  c.time_ms = 24'd105000;
            4'd9:  begin c.time_ms = 24'd116000; c.dir = DIR_REV; end
            4'd10: c.time_ms = 24'd138000;
            4'd11: begin c.time_ms = 24'd150000; c.dir = DIR_REV; end
            4'd12: c.time_ms = 24'd161000;
            4'd13: begin c.time_ms = 24'd172000; c.dir = DIR_REV; end
            default:
            begin
                c.time_ms   = '0;
                c.intensity = '0;
            end
        endcase
        return c;
    endfunction

endpackage

/* design/tccs_if.sv */
// Valid/ready channel interfaces of the cue crossing scheduler.
interface tccs_in_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic signed [tccs_pkg::NOW_W-1:0] now_ms;
    modport source(output valid, kind, now_ms, input ready);
    modport sink(input valid, kind, now_ms, output ready);
endinterface

interface tccs_out_if;
    logic                                    valid;
    logic                                    ready;
    logic [tccs_pkg::IDX_W-1:0]              cue_index;
    logic [tccs_pkg::CUE_TIME_W-1:0]         cue_time_ms;
    logic signed [tccs_pkg::DIR_W-1:0]       cue_direction;
    logic [tccs_pkg::INTENS_W-1:0]           cue_intensity;
    logic                                    last_of_run;
    modport source(output valid, cue_index, cue_time_ms, cue_direction, cue_intensity,
                   last_of_run, input ready);
    modport sink(input valid, cue_index, cue_time_ms, cue_direction, cue_intensity,
                 last_of_run, output ready);
endinterface

interface tccs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tccs_pkg::TOL_W-1:0]      rewind_tolerance_ms;
    modport source(output valid, rewind_tolerance_ms, input ready);
    modport sink(input valid, rewind_tolerance_ms, output ready);
endinterface

/* design/timeline_cue_crossing_scheduler_core.sv */
// One compare unit is shared, so an item is taken only in idle, after the last walk ends;
// the cue table is walked one cue per cycle, stalling in a scan while the output is held.
// Restart or resync: the seek walks past the cues at or before the position (at most 14).
// Crossing sample: crossed cues go out through the hold register, the last one marked.
// Reset (rst_n low, asynchronous): unsynchronised, position 0, pointer 0, tolerance 10 ms.
// Tolerance writes are taken at any cycle and apply to the next sample.
module timeline_cue_crossing_scheduler_core #(
    parameter int CUE_COUNT = 14,
    parameter int TIME_BITS = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    tccs_cfg_if.sink      cfg,
    tccs_in_if.sink       sample_in,
    tccs_out_if.source    cue_out
);

    // Walk request from the sequencer: current table pointer and the position bound
    logic [tccs_pkg::IDX_W-1:0] walk_ptr;
    logic [TIME_BITS-1:0]       walk_bound;
    // Walk answer: the addressed cue and whether it lies at or before the bound
    tccs_pkg::walk_rsp_t        walk_rsp;

    // Sequencer: holds position, pointer and synchronised flag, and owns the
    // result register so the next sample can enter while a word waits
    tccs_ctrl #(
        .CUE_COUNT (CUE_COUNT),
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .sample_in  (sample_in),
        .cue_out    (cue_out),
        .walk_ptr   (walk_ptr),
        .walk_bound (walk_bound),
        .walk_rsp   (walk_rsp)
    );

    // Shared compare unit, used both for the restart or resync search and the crossing scan
    tccs_walk_unit #(
        .CUE_COUNT (CUE_COUNT),
        .TIME_BITS (TIME_BITS)
    ) u_walk (
        .ptr   (walk_ptr),
        .bound (walk_bound),
        .rsp   (walk_rsp)
    );

endmodule

/* design/tccs_walk_unit.sv */
// Shared table walk unit: reads one cue and compares its time with a bound.
module tccs_walk_unit #(
    parameter int CUE_COUNT = 14,
    parameter int TIME_BITS = 24
) (
    input  logic [tccs_pkg::IDX_W-1:0] ptr,
    input  logic [TIME_BITS-1:0]       bound,
    output tccs_pkg::walk_rsp_t        rsp
);

    localparam int ACTIVE_INT = (CUE_COUNT < tccs_pkg::TABLE_LEN) ?
                                CUE_COUNT : tccs_pkg::TABLE_LEN;
    localparam logic [tccs_pkg::IDX_W-1:0] ACTIVE = tccs_pkg::IDX_W'(ACTIVE_INT);

    tccs_pkg::cue_t cue;

    always_comb
    begin
        cue      = tccs_pkg::cue_lookup(ptr);
        rsp.cue  = cue;
        // hit: the cue exists and lies at or before the bound
        rsp.hit  = (ptr < ACTIVE) &&
                   (tccs_pkg::CMP_W'(cue.time_ms) <= tccs_pkg::CMP_W'(bound));
    end

endmodule

/* design/tccs_ctrl.sv */
// Sequencer, position state and result register of the cue crossing scheduler.
`include "timeline_cue_crossing_scheduler_core_defines.svh"

module tccs_ctrl #(
    parameter int CUE_COUNT = 14,
    parameter int TIME_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tccs_cfg_if.sink                      cfg,
    tccs_in_if.sink                       sample_in,
    tccs_out_if.source                    cue_out,
    output logic [tccs_pkg::IDX_W-1:0]    walk_ptr,
    output logic [TIME_BITS-1:0]          walk_bound,
    input  tccs_pkg::walk_rsp_t           walk_rsp
);

    localparam int CW = tccs_pkg::CMP_W;
    localparam int ACTIVE_INT = (CUE_COUNT < tccs_pkg::TABLE_LEN) ?
                                CUE_COUNT : tccs_pkg::TABLE_LEN;
    localparam logic [tccs_pkg::IDX_W-1:0] ACTIVE = tccs_pkg::IDX_W'(ACTIVE_INT);
    localparam logic [CW-1:0] TMAX = (CW'(1) << TIME_BITS) - CW'(1);

    tccs_pkg::ctrl_state_t              state_reg, state_next;
    logic [tccs_pkg::IDX_W-1:0]         ptr_reg, ptr_next;
    logic [TIME_BITS-1:0]               prev_reg, prev_next;
    logic [TIME_BITS-1:0]               pos_reg, pos_next;
    logic                               synced_reg, synced_next;
    logic [tccs_pkg::TOL_W-1:0]         tol_reg;
    logic                               hold_valid_reg, hold_valid_next;
    logic [tccs_pkg::IDX_W-1:0]         hold_idx_reg, hold_idx_next;
    tccs_pkg::cue_t                     hold_cue_reg, hold_cue_next;
    logic                               out_valid_reg, out_valid_next;
    logic [tccs_pkg::IDX_W-1:0]         out_idx_reg;
    tccs_pkg::cue_t                     out_cue_reg;
    logic                               out_last_reg;

    logic [CW-1:0]                      raw_mag;
    logic [CW-1:0]                      clamp_val;
    logic [TIME_BITS-1:0]               pos_in;
    logic [TIME_BITS:0]                 reach;
    logic                               seek_jump;
    logic                               out_free;
    logic                               load_out;
    logic                               load_last;
    logic [tccs_pkg::IDX_W-1:0]         load_idx;

    assign cfg.ready       = 1'b1;
    assign sample_in.ready = (state_reg == tccs_pkg::ST_IDLE);

    assign walk_ptr   = ptr_reg;
    assign walk_bound = pos_reg;

    assign cue_out.valid         = out_valid_reg;
    assign cue_out.cue_index     = out_idx_reg;
    assign cue_out.cue_time_ms   = out_cue_reg.time_ms;
    assign cue_out.cue_direction = out_cue_reg.dir;
    assign cue_out.cue_intensity = out_cue_reg.intensity;
    assign cue_out.last_of_run   = out_last_reg;

    // clamp the incoming sample: negative to zero, large to the time range
    always_comb
    begin
        raw_mag = {{(CW - 24){1'b0}}, sample_in.now_ms[23:0]};
        if (sample_in.now_ms[tccs_pkg::NOW_W-1])
            clamp_val = '0;
        else if (raw_mag > TMAX)
            clamp_val = TMAX;
        else
            clamp_val = raw_mag;
        pos_in    = clamp_val[TIME_BITS-1:0];
        reach     = (TIME_BITS + 1)'(pos_in) + (TIME_BITS + 1)'(tol_reg);
        seek_jump = reach < (TIME_BITS + 1)'(prev_reg);
    end

    assign out_free = !out_valid_reg || cue_out.ready;

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        prev_next       = prev_reg;
        pos_next        = pos_reg;
        synced_next     = synced_reg;
        hold_valid_next = hold_valid_reg;
        hold_idx_next   = hold_idx_reg;
        hold_cue_next   = hold_cue_reg;
        load_out        = 1'b0;
        load_last       = 1'b0;
        load_idx        = hold_idx_reg;

        unique case (state_reg)
            tccs_pkg::ST_IDLE:
            begin
                if (sample_in.valid)
                begin
                    if (sample_in.kind == tccs_pkg::KIND_RESTART)
                    begin
                        pos_next    = '0;
                        prev_next   = '0;
                        ptr_next    = '0;
                        synced_next = 1'b1;
                        state_next  = tccs_pkg::ST_SEEK;
                    end
                    else if (!synced_reg || seek_jump)
                    begin
                        pos_next    = pos_in;
                        prev_next   = pos_in;
                        ptr_next    = '0;
                        synced_next = 1'b1;
                        state_next  = tccs_pkg::ST_SEEK;
                    end
                    else
                    begin
                        pos_next   = pos_in;
                        state_next = tccs_pkg::ST_SCAN;
                    end
                end
            end
            tccs_pkg::ST_SEEK:
            begin
                if (walk_rsp.hit)
                    ptr_next = ptr_reg + 1'b1;
                else
                    state_next = tccs_pkg::ST_IDLE;
            end
            tccs_pkg::ST_SCAN:
            begin
                if (walk_rsp.hit)
                begin
                    if (!hold_valid_reg || out_free)
                    begin
                        load_out        = hold_valid_reg;
                        hold_idx_next   = ptr_reg;
                        hold_cue_next   = walk_rsp.cue;
                        hold_valid_next = 1'b1;
                        ptr_next        = ptr_reg + 1'b1;
                    end
                end
                else if (!hold_valid_reg)
                begin
                    prev_next  = pos_reg;
                    state_next = tccs_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    load_out        = 1'b1;
                    load_last       = 1'b1;
                    hold_valid_next = 1'b0;
                    prev_next       = pos_reg;
                    state_next      = tccs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tccs_pkg::ST_IDLE;
            end
        endcase

        if (load_out)
            out_valid_next = 1'b1;
        else if (cue_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tccs_pkg::ST_IDLE;
            ptr_reg        <= '0;
            prev_reg       <= '0;
            pos_reg        <= '0;
            synced_reg     <= 1'b0;
            tol_reg        <= tccs_pkg::TOL_RESET;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            prev_reg       <= prev_next;
            pos_reg        <= pos_next;
            synced_reg     <= synced_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid)
                tol_reg <= cfg.rewind_tolerance_ms;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_idx_reg <= hold_idx_next;
        hold_cue_reg <= hold_cue_next;
        if (load_out)
        begin
            out_idx_reg  <= load_idx;
            out_cue_reg  <= hold_cue_reg;
            out_last_reg <= load_last;
        end
    end

    `TCCS_ASSERT_NOW(a_ptr_in_range, 1'b1, ptr_reg <= ACTIVE, "cue pointer past table end")
    `TCCS_ASSERT_NOW(a_hold_only_in_scan, state_reg != tccs_pkg::ST_SCAN, !hold_valid_reg,
        "held cue outside scan")
    `TCCS_ASSERT_NEXT(a_last_ends_run, load_out && load_last, state_reg == tccs_pkg::ST_IDLE,
        "run marked last but sequencer still busy")
    `TCCS_ASSERT_NOW(a_seek_synced, state_reg == tccs_pkg::ST_SEEK, synced_reg,
        "seek walk without synchronised flag")

endmodule
